// ===== sv/double_ended_record_queue_macros.svh =====
// Assertion macros for the double-ended record queue.
// Used by the RTL files in this folder; no other dependencies.
`ifndef DOUBLE_ENDED_RECORD_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_RECORD_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define DERQ_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("queue invariant violated");
// Check that the consequent holds in the same cycle as the antecedent.
`define DERQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue same-cycle check failed");
// Check that the consequent holds in the cycle after the antecedent.
`define DERQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue next-cycle check failed");
`else
`define DERQ_ASSERT_ALWAYS(label, clk, rst, cond)
`define DERQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DERQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/derq_pkg.sv =====
// Shared types and constants for the double-ended record queue.
// No dependencies; imported by the RAM and the top level.
package derq_pkg;

  localparam int ID_W      = 32;
  localparam int SAL_W     = 31;
  localparam int REC_W     = ID_W + SAL_W;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 4;
  localparam int CNT_W     = 5;
  localparam int LIST_MAX  = 16;
  localparam int LEFT_W    = $clog2(LIST_MAX);
  localparam int DEPTH_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LIST
  } state_t;

endpackage

// ===== sv/derq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on derq_pkg for default sizes.
module derq_ram #(
  parameter int WIDTH = derq_pkg::REC_W,
  parameter int DEPTH = derq_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  import derq_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry; hold read data when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/double_ended_record_queue.sv =====
// Each accepted command is held and run in S_EXEC. Push, and any command on an empty
// queue, loads its beat from S_EXEC; pop reads the record RAM in S_EXEC and loads its
// beat from S_READ. A list reads the front entry in S_EXEC, then streams up to LIST_MAX
// entries from S_LIST, one beat per cycle while the output is not stalled.
// Reset (rst, synchronous) empties the queue: front pointer and occupancy clear,
// record RAM contents are left as they are and never read before written.
`include "double_ended_record_queue_macros.svh"

module double_ended_record_queue #(
  parameter int DEPTH = derq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [derq_pkg::CMD_W-1:0]  command,
  input  logic [derq_pkg::ID_W-1:0]   record_id,
  input  logic [derq_pkg::SAL_W-1:0]  record_salary,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [derq_pkg::ID_W-1:0]   out_id,
  output logic [derq_pkg::SAL_W-1:0]  out_salary,
  output logic [derq_pkg::POS_W-1:0]  position,
  output logic [derq_pkg::CNT_W-1:0]  entry_count,
  output logic                        last
);
  import derq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);

  // Ring slot of base + off, with base < DEPTH and off <= DEPTH
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_t              state, state_next;
  logic [CMD_W-1:0]    cmd;
  logic [ID_W-1:0]     rec_id;
  logic [SAL_W-1:0]    rec_sal;
  logic [AW-1:0]       fp, fp_next;
  logic [OW-1:0]       occ, occ_next;
  logic [AW-1:0]       lp, lp_next;
  logic [POS_W-1:0]    idx, idx_next;
  logic [LEFT_W-1:0]   list_left, list_left_next;

  logic                out_free, out_load;
  logic [1:0]          res_status;
  logic [ID_W-1:0]     res_id;
  logic [SAL_W-1:0]    res_sal;
  logic [POS_W-1:0]    res_pos;
  logic [CNT_W-1:0]    res_cnt;
  logic                res_last;

  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [REC_W-1:0]    rd_data;

  logic                is_push, is_pop, is_list, is_front, full, empty;
  logic [AW-1:0]       fp_inc, fp_dec, lp_inc;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Decode the held command
  assign is_push  = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);
  assign is_pop   = (cmd == CMD_POP_FRONT) || (cmd == CMD_POP_BACK);
  assign is_list  = (cmd == CMD_LIST);
  assign is_front = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_POP_FRONT);
  assign full     = (occ == OW'(DEPTH));
  assign empty    = (occ == '0);
  assign fp_inc   = wrap_add(fp, (AW+1)'(1));
  assign fp_dec   = (fp == '0) ? AW'(DEPTH - 1) : fp - AW'(1);
  assign lp_inc   = wrap_add(lp, (AW+1)'(1));

  // Record store
  derq_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({rec_id, rec_sal}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (is_push || ((is_pop || is_list) && empty)) begin
          if (out_free) state_next = S_IDLE;
        end else if (is_pop) begin
          state_next = S_READ;
        end else if (is_list) begin
          state_next = S_LIST;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) state_next = S_IDLE;
      end
      S_LIST: begin
        if (out_free && list_left == '0) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory access, pointer update and result forming
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = is_front ? fp_dec : wrap_add(fp, (AW+1)'(occ));
    rd_en          = 1'b0;
    rd_addr        = fp;
    fp_next        = fp;
    occ_next       = occ;
    lp_next        = lp;
    idx_next       = idx;
    list_left_next = list_left;
    out_load       = 1'b0;
    res_status     = ST_OK;
    res_id         = '0;
    res_sal        = '0;
    res_pos        = '0;
    res_cnt        = CNT_W'(occ);
    res_last       = 1'b1;
    case (state)
      S_EXEC: begin
        if (is_push) begin
          if (out_free) begin
            out_load = 1'b1;
            if (full) begin
              res_status = ST_FULL;
            end else begin
              wr_en    = 1'b1;
              occ_next = occ + OW'(1);
              res_cnt  = CNT_W'(occ + OW'(1));
              if (is_front) fp_next = fp_dec;
            end
          end
        end else if ((is_pop || is_list) && empty) begin
          if (out_free) begin
            out_load   = 1'b1;
            res_status = ST_EMPTY;
            res_cnt    = '0;
          end
        end else if (is_pop) begin
          // Read the removed entry and retire it now
          rd_en    = 1'b1;
          rd_addr  = is_front ? fp : wrap_add(fp, (AW+1)'(occ - OW'(1)));
          occ_next = occ - OW'(1);
          if (is_front) fp_next = fp_inc;
        end else if (is_list) begin
          // Start the walk at the front entry
          rd_en    = 1'b1;
          rd_addr  = fp;
          lp_next  = fp;
          idx_next = '0;
          if (32'(occ) >= LIST_MAX) begin
            list_left_next = LEFT_W'(LIST_MAX - 1);
          end else begin
            list_left_next = LEFT_W'(occ - OW'(1));
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          res_id   = rd_data[REC_W-1 -: ID_W];
          res_sal  = rd_data[SAL_W-1:0];
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_load = 1'b1;
          res_id   = rd_data[REC_W-1 -: ID_W];
          res_sal  = rd_data[SAL_W-1:0];
          res_pos  = idx;
          res_last = (list_left == '0);
          // Advance to the next entry
          if (list_left != '0) begin
            rd_en          = 1'b1;
            rd_addr        = lp_inc;
            lp_next        = lp_inc;
            idx_next       = idx + POS_W'(1);
            list_left_next = list_left - LEFT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fp    <= '0;
      occ   <= '0;
    end else begin
      state <= state_next;
      fp    <= fp_next;
      occ   <= occ_next;
    end
  end

  // Hold the accepted command and walk state
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd     <= command;
      rec_id  <= record_id;
      rec_sal <= record_salary;
    end
    lp        <= lp_next;
    idx       <= idx_next;
    list_left <= list_left_next;
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      out_id      <= res_id;
      out_salary  <= res_sal;
      position    <= res_pos;
      entry_count <= res_cnt;
      last        <= res_last;
    end
  end

  `DERQ_ASSERT_ALWAYS(a_occ_bound, clk, rst, occ <= OW'(DEPTH))
  `DERQ_ASSERT_NEXT(a_push_grows, clk, rst, state == S_EXEC && is_push && !full && out_free, occ == $past(occ) + OW'(1))
  `DERQ_ASSERT_NEXT(a_list_ends, clk, rst, state == S_LIST && out_free && list_left == '0, out_valid && last && state == S_IDLE)
  `DERQ_ASSERT_IMPLY(a_no_write_in_read, clk, rst, state == S_READ || state == S_LIST, !wr_en)

endmodule
